[rtl/ks_two_sample_path_count_assert.svh]
// Assertion macros for the two-sample path counter.
// Used by the top level only; needs clk and rst_n in the scope of each use.
`ifndef KS_TWO_SAMPLE_PATH_COUNT_ASSERT_SVH
`define KS_TWO_SAMPLE_PATH_COUNT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define KSPC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kspc: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define KSPC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kspc: next-cycle check failed");
`else
`define KSPC_ASSERT_IMPL(name, ante, cons)
`define KSPC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[rtl/kspc_pkg.sv]
// Shared types and widths for the two-sample path counter.
// No dependencies; used by kspc_cell and ks_two_sample_path_count.
`default_nettype none

package kspc_pkg;

    localparam int N_W   = 6;   // zeros and ones count fields
    localparam int D_W   = 11;  // scaled deviation field
    localparam int KT_W  = 7;   // anti-diagonal index, up to 64
    localparam int DEV_W = 13;  // signed node deviation, -2048..2048
    localparam int CNT_W = 61;  // path counts, at most C(64,32)

    // Query transaction.
    typedef struct packed {
        logic [N_W-1:0] zeros_count;
        logic [N_W-1:0] ones_count;
        logic [D_W-1:0] scaled_deviation;
    } query_t;

    // Result transaction.
    typedef struct packed {
        logic [CNT_W-1:0] exceeding_paths;
        logic [CNT_W-1:0] total_paths;
    } result_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic            load;      // start a new query
        logic            step;      // advance one anti-diagonal
        logic [KT_W-1:0] load_sum;  // n0 + n1 of the query being loaded
        logic [N_W-1:0]  n0;
        logic [N_W-1:0]  n1;
        logic [KT_W-1:0] kt;        // anti-diagonal being computed
        logic [D_W-1:0]  d;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/kspc_cell.sv]
// One lattice cell: holds the band and total path counts for one zeros index.
// Depends on kspc_pkg; instantiated in a row by ks_two_sample_path_count.
`default_nettype none

module kspc_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                       clk,
    input  wire kspc_pkg::cell_ctrl_t       ctrl,
    input  wire logic [kspc_pkg::CNT_W-1:0] left_all,
    input  wire logic [kspc_pkg::CNT_W-1:0] left_band,
    output logic      [kspc_pkg::CNT_W-1:0] all_count,
    output logic      [kspc_pkg::CNT_W-1:0] band_count
);

    localparam int N_W   = kspc_pkg::N_W;
    localparam int D_W   = kspc_pkg::D_W;
    localparam int KT_W  = kspc_pkg::KT_W;
    localparam int DEV_W = kspc_pkg::DEV_W;
    localparam int CNT_W = kspc_pkg::CNT_W;

    localparam logic [KT_W-1:0]  IDX_K = KT_W'(INDEX);
    localparam logic [N_W-1:0]   IDX_N = N_W'(INDEX);
    localparam logic [DEV_W-1:0] IDX_D = DEV_W'(INDEX);

    logic [CNT_W-1:0]        all_reg, all_next;
    logic [CNT_W-1:0]        band_reg, band_next;
    logic signed [DEV_W-1:0] dev_reg, dev_next;
    logic signed [DEV_W-1:0] dev_now;
    logic [DEV_W-1:0]        dev_mag;
    logic [DEV_W-1:0]        dev_load;
    logic [KT_W-1:0]         k1;
    logic                    active;
    logic                    in_band;

    // The deviation i*(n0+n1) - kt*n0 drops by n0 on every anti-diagonal.
    assign dev_now  = dev_reg - $signed({{(DEV_W-N_W){1'b0}}, ctrl.n0});
    assign dev_mag  = dev_now[DEV_W-1] ? $unsigned(-dev_now) : $unsigned(dev_now);
    assign in_band  = dev_mag < {{(DEV_W-D_W){1'b0}}, ctrl.d};
    assign dev_load = IDX_D * {{(DEV_W-KT_W){1'b0}}, ctrl.load_sum};

    // The node is live when it lies inside the rectangle on this anti-diagonal.
    assign k1     = ctrl.kt - IDX_K;
    assign active = (IDX_N <= ctrl.n0) && (ctrl.kt >= IDX_K)
                    && (k1 <= {{(KT_W-N_W){1'b0}}, ctrl.n1});

    // Next counts: paths arrive from this node and from the left neighbor.
    always_comb
    begin
        all_next  = all_reg;
        band_next = band_reg;
        dev_next  = dev_reg;
        if (ctrl.load)
        begin
            all_next  = CNT_W'(INDEX == 0);
            band_next = CNT_W'(INDEX == 0);
            dev_next  = $signed(dev_load);
        end
        else if (ctrl.step)
        begin
            all_next  = active ? (all_reg + left_all) : '0;
            band_next = (active && in_band) ? (band_reg + left_band) : '0;
            dev_next  = dev_now;
        end
    end

    // Cell storage.
    always_ff @(posedge clk)
    begin
        all_reg  <= all_next;
        band_reg <= band_next;
        dev_reg  <= dev_next;
    end

    assign all_count  = all_reg;
    assign band_count = band_reg;

endmodule

`default_nettype wire

[rtl/ks_two_sample_path_count.sv]
// The result is registered once the row has stepped through anti-diagonals 1 to n0+n1
// and the output is free. Throughput: one query at a time; the next is taken once the
// result is registered. The row of cells advances one anti-diagonal per cycle.
// A zero deviation, or a query with no zeros and no ones, skips the stepping.
// Reset (rst_n, asynchronous, active low) clears the sequencer and the result valid.
// Cell contents are not reset; every query loads them before use.
`default_nettype none

module ks_two_sample_path_count #(
    parameter int MAX_ZEROS = 32,
    parameter int MAX_ONES  = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              query_valid,
    output logic                   query_stall,
    input  wire kspc_pkg::query_t  query,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output kspc_pkg::result_t      result
);

    `include "ks_two_sample_path_count_assert.svh"

    localparam int N_W   = kspc_pkg::N_W;
    localparam int D_W   = kspc_pkg::D_W;
    localparam int KT_W  = kspc_pkg::KT_W;
    localparam int CNT_W = kspc_pkg::CNT_W;
    localparam int CELLS = MAX_ZEROS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [N_W-1:0]      n0_reg;
    logic [N_W-1:0]      n1_reg;
    logic [D_W-1:0]      d_reg;
    logic [KT_W-1:0]     kt_reg;
    logic [KT_W-1:0]     sum_reg;
    logic                result_valid_reg;
    kspc_pkg::result_t   result_reg;

    logic                 accept;
    logic                 out_free;
    logic [N_W-1:0]       n0_sat;
    logic [N_W-1:0]       n1_sat;
    logic [KT_W-1:0]      load_sum;
    logic [KT_W-1:0]      kt_step;
    kspc_pkg::cell_ctrl_t ctrl;
    logic [CNT_W-1:0]     all_q  [CELLS];
    logic [CNT_W-1:0]     band_q [CELLS];
    logic [CNT_W-1:0]     sel_all;
    logic [CNT_W-1:0]     sel_band;

    // Input handshake and count saturation.
    assign query_stall = (state_reg != ST_IDLE);
    assign accept      = query_valid && !query_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign n0_sat      = (query.zeros_count > N_W'(MAX_ZEROS)) ? N_W'(MAX_ZEROS)
                                                               : query.zeros_count;
    assign n1_sat      = (query.ones_count > N_W'(MAX_ONES)) ? N_W'(MAX_ONES)
                                                             : query.ones_count;
    assign load_sum    = {1'b0, n0_sat} + {1'b0, n1_sat};
    assign kt_step     = kt_reg + KT_W'(1);

    // Control broadcast to the row of cells.
    always_comb
    begin
        ctrl          = '0;
        ctrl.load     = accept;
        ctrl.step     = (state_reg == ST_RUN);
        ctrl.load_sum = load_sum;
        ctrl.n0       = n0_reg;
        ctrl.n1       = n1_reg;
        ctrl.kt       = kt_step;
        ctrl.d        = d_reg;
    end

    // Row of cells; each takes its left neighbor's counts, cell 0 takes zero.
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            kspc_cell #(
                .INDEX (i)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_all   ('0),
                .left_band  ('0),
                .all_count  (all_q[i]),
                .band_count (band_q[i])
            );
        end
        else
        begin : g_rest
            kspc_cell #(
                .INDEX (i)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .left_all   (all_q[i-1]),
                .left_band  (band_q[i-1]),
                .all_count  (all_q[i]),
                .band_count (band_q[i])
            );
        end
    end

    // Pick the counts of the corner node (n0, n1).
    always_comb
    begin
        sel_all  = '0;
        sel_band = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            sel_all  = sel_all  | (all_q[i]  & {CNT_W{n0_reg == N_W'(i)}});
            sel_band = sel_band | (band_q[i] & {CNT_W{n0_reg == N_W'(i)}});
        end
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            n0_reg           <= '0;
            n1_reg           <= '0;
            d_reg            <= '0;
            kt_reg           <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // The result valid rises when a new result is written and drops once taken.
            if ((state_reg == ST_FINISH) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        n0_reg  <= n0_sat;
                        n1_reg  <= n1_sat;
                        d_reg   <= query.scaled_deviation;
                        kt_reg  <= '0;
                        sum_reg <= load_sum;
                        if ((query.scaled_deviation == '0) || (load_sum == '0))
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    kt_reg <= kt_step;
                    if (kt_step == sum_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        if (d_reg == '0)
                        begin
                            result_reg.exceeding_paths <= CNT_W'(1);
                            result_reg.total_paths     <= CNT_W'(1);
                        end
                        else
                        begin
                            result_reg.exceeding_paths <= sel_all - sel_band;
                            result_reg.total_paths     <= sel_all;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A query transaction always starts work on the row.
    `KSPC_ASSERT_NEXT(a_accept_starts, accept, (state_reg == ST_RUN) || (state_reg == ST_FINISH))
    // The anti-diagonal index stays below the query's n0+n1 while stepping.
    `KSPC_ASSERT_IMPL(a_kt_in_range, state_reg == ST_RUN, kt_reg < sum_reg)
    // Exceeding paths never outnumber all paths.
    `KSPC_ASSERT_IMPL(a_band_subset, result_valid_reg, result_reg.exceeding_paths <= result_reg.total_paths)

endmodule

`default_nettype wire

[sim/tb_ks_two_sample_path_count.sv]
// Self-checking testbench for ks_two_sample_path_count, the exact two-sample path counter.
// Depends on kspc_pkg for the query and result transaction types, and on ks_two_sample_path_count.
`timescale 1ns / 100ps

module tb_ks_two_sample_path_count;

    localparam int N_W          = kspc_pkg::N_W;
    localparam int D_W          = kspc_pkg::D_W;
    localparam int CNT_W        = kspc_pkg::CNT_W;
    localparam int MAX_ZEROS    = 32;
    localparam int MAX_ONES     = 32;
    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_PERCENT = 37;
    localparam int DRAIN_CYCLES = 70;
    localparam int REPORT_LIMIT = 10;
    // C(64,32), the largest binomial count the block can return.
    localparam logic [CNT_W-1:0] CENTRAL_BINOMIAL = 61'd1832624140942590534;

    // One row of the directed table. The expected value is used only when known is set.
    typedef struct {
        kspc_pkg::query_t  q;
        bit                known;
        kspc_pkg::result_t res;
    } directed_row_t;

    logic              clk;
    logic              rst_n;
    logic              query_valid;
    logic              query_stall;
    kspc_pkg::query_t  query;
    logic              result_valid;
    logic              result_stall;
    kspc_pkg::result_t result;

    kspc_pkg::result_t pending_results[$];
    directed_row_t     directed_rows[$];
    int                error_count;
    int                mismatch_count;
    bit                calm;

    ks_two_sample_path_count #(
        .MAX_ZEROS (MAX_ZEROS),
        .MAX_ONES  (MAX_ONES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .query        (query),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Count the lattice paths of one query: all of them, and those that leave the band.
    function automatic kspc_pkg::result_t predict_path_counts(input kspc_pkg::query_t q);
        logic [62:0]       band_cnt [0:MAX_ZEROS];
        logic [62:0]       all_cnt [0:MAX_ZEROS];
        logic [62:0]       a;
        logic [62:0]       b;
        kspc_pkg::result_t r;
        int                n0;
        int                n1;
        int                d;
        int                kt;
        int                i;
        int                k1;
        int                diff;
        begin
            n0 = q.zeros_count;
            n1 = q.ones_count;
            d  = q.scaled_deviation;
            if (n0 > MAX_ZEROS)
                n0 = MAX_ZEROS;
            if (n1 > MAX_ONES)
                n1 = MAX_ONES;
            if (d == 0)
            begin
                r.exceeding_paths = CNT_W'(1);
                r.total_paths     = CNT_W'(1);
                return r;
            end
            for (i = 0; i <= MAX_ZEROS; i++)
            begin
                band_cnt[i] = '0;
                all_cnt[i]  = '0;
            end
            band_cnt[0] = 1;
            all_cnt[0]  = 1;
            // Walk the anti-diagonals, updating from the high index down so that
            // the neighbor below still holds the previous diagonal.
            for (kt = 1; kt <= n0 + n1; kt++)
            begin
                for (i = n0; i >= 0; i--)
                begin
                    k1 = kt - i;
                    if (k1 < 0 || k1 > n1)
                    begin
                        band_cnt[i] = '0;
                        all_cnt[i]  = '0;
                    end
                    else
                    begin
                        a = all_cnt[i];
                        b = band_cnt[i];
                        if (i > 0)
                        begin
                            a = a + all_cnt[i-1];
                            b = b + band_cnt[i-1];
                        end
                        diff = i * n1 - k1 * n0;
                        if (diff < 0)
                            diff = -diff;
                        all_cnt[i]  = a;
                        band_cnt[i] = (diff < d) ? b : '0;
                    end
                end
            end
            r.exceeding_paths = CNT_W'(all_cnt[n0] - band_cnt[n0]);
            r.total_paths     = CNT_W'(all_cnt[n0]);
            return r;
        end
    endfunction

    // Append a directed row; a row without a typed result is checked by the predictor.
    task automatic add_row(input int n0, input int n1, input int d, input bit known,
                           input logic [CNT_W-1:0] exc, input logic [CNT_W-1:0] tot);
        directed_row_t row;
        begin
            row.q.zeros_count      = N_W'(n0);
            row.q.ones_count       = N_W'(n1);
            row.q.scaled_deviation = D_W'(d);
            row.known              = known;
            row.res.exceeding_paths = exc;
            row.res.total_paths     = tot;
            directed_rows.push_back(row);
        end
    endtask

    // Offer one query transaction, with random idle cycles first, and record what it
    // should return once it is accepted. Called and left at a falling edge.
    task automatic send_query(input kspc_pkg::query_t q, input kspc_pkg::result_t res);
        begin
            while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
            begin
                query_valid = 1'b0;
                query       = kspc_pkg::query_t'($urandom);
                @(negedge clk);
            end
            query_valid = 1'b1;
            query       = q;
            do
                @(posedge clk);
            while (query_stall);
            pending_results.push_back(res);
            @(negedge clk);
        end
    endtask

    // Receiver side: stall the result channel at random unless in the calm stretch.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall = !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        kspc_pkg::result_t exp_res;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected result: exceeding %0d total %0d",
                             result.exceeding_paths, result.total_paths);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (result.exceeding_paths !== exp_res.exceeding_paths ||
                    result.total_paths !== exp_res.total_paths)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Mismatch: exceeding exp %0d got %0d, total exp %0d got %0d",
                                 exp_res.exceeding_paths, result.exceeding_paths,
                                 exp_res.total_paths, result.total_paths);
                end
            end
        end
    end

    // Run limit: far beyond the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("Verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, random queries, drain.
    initial
    begin
        kspc_pkg::query_t  q;
        kspc_pkg::result_t res;
        int                n0;
        int                n1;
        int                area;
        int                pick;
        int                d;

        rst_n          = 1'b0;
        query_valid    = 1'b0;
        query          = '0;
        error_count    = 0;
        mismatch_count = 0;
        calm           = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: zero deviation, extremes, saturation, zero counts.
        add_row(1, 1, 0, 1'b1, 1, 1);
        add_row(32, 32, 0, 1'b1, 1, 1);
        add_row(63, 5, 0, 1'b1, 1, 1);
        add_row(1, 1, 1, 1'b1, 2, 2);
        add_row(32, 32, 2047, 1'b1, 0, CENTRAL_BINOMIAL);
        add_row(32, 32, 1025, 1'b1, 0, CENTRAL_BINOMIAL);
        add_row(63, 63, 1, 1'b1, CENTRAL_BINOMIAL, CENTRAL_BINOMIAL);
        add_row(0, 5, 3, 1'b1, 0, 1);
        add_row(5, 0, 7, 1'b1, 0, 1);
        add_row(0, 0, 2047, 1'b1, 0, 1);
        add_row(32, 32, 1024, 1'b0, 0, 0);
        add_row(32, 32, 1, 1'b0, 0, 0);
        add_row(32, 1, 16, 1'b0, 0, 0);
        add_row(1, 32, 17, 1'b0, 0, 0);
        add_row(48, 40, 1365, 1'b0, 0, 0);
        add_row(33, 31, 682, 1'b0, 0, 0);
        add_row(7, 9, 63, 1'b0, 0, 0);
        add_row(7, 9, 64, 1'b0, 0, 0);
        add_row(16, 16, 32, 1'b0, 0, 0);
        add_row(3, 2, 5, 1'b0, 0, 0);

        @(negedge clk);
        foreach (directed_rows[r])
        begin
            res = directed_rows[r].known ? directed_rows[r].res
                                         : predict_path_counts(directed_rows[r].q);
            send_query(directed_rows[r].q, res);
        end

        // Random queries: mostly legal sizes, some zero or oversized counts,
        // deviations spread over the range and bunched around n0*n1.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            calm = (k >= 500 && k < 700);
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                n0 = $urandom_range(0, 1) ? 0 : $urandom_range(0, 63);
                n1 = (n0 != 0) ? 0 : $urandom_range(0, 63);
            end
            else if (pick < 15)
            begin
                n0 = $urandom_range(0, 63);
                n1 = $urandom_range(0, 63);
            end
            else
            begin
                n0 = $urandom_range(1, 32);
                n1 = $urandom_range(1, 32);
            end
            area = ((n0 > MAX_ZEROS) ? MAX_ZEROS : n0) * ((n1 > MAX_ONES) ? MAX_ONES : n1);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                d = 0;
            else if (pick < 23)
                d = $urandom_range(0, 2047);
            else if (pick < 43)
                d = area + $urandom_range(0, 4) - 2;
            else
                d = $urandom_range(1, (area > 0) ? area : 1);
            if (d < 0)
                d = 0;
            q.zeros_count      = N_W'(n0);
            q.ones_count       = N_W'(n1);
            q.scaled_deviation = D_W'(d);
            send_query(q, predict_path_counts(q));
        end
        calm        = 1'b0;
        query_valid = 1'b0;

        // Drain: wait for every result, then a little longer for strays.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
